### rtl/core/iol_pkg.sv
// Shared types for the indexed ordered list: command codes, command and
// result words, and the sequencer states. No dependencies.
package iol_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 9;

    typedef enum logic [2:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_BACK  = 3'd1,
        CMD_ADD_AT    = 3'd2,
        CMD_RM_FRONT  = 3'd3,
        CMD_RM_BACK   = 3'd4,
        CMD_RM_AT     = 3'd5,
        CMD_GET       = 3'd6,
        CMD_NOP       = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic                     ok;
        logic [LEN_W-1:0]         length;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_W,
        S_PUT,
        S_RMV,
        S_RMV_W,
        S_GET,
        S_GET_W
    } t_state;

endpackage

### rtl/core/indexed_ordered_list.sv
// Indexed ordered list top level: sequencer around one element RAM.
// Depends on iol_pkg and iol_ram.
// NOP or a failing command strobes the cycle after accept. Inserts at k < count
// first move slots k and above up one; removes move the slots above k down one.
// One command at a time: busy holds while the shift loop moves one word per cycle
// through the single RAM read port. Results are strobes; the receiver cannot stall.
// Reset (synchronous, active low) empties the list; the RAM is not cleared.
module indexed_ordered_list #(
    parameter int CAPACITY = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  iol_pkg::t_in  i_cmd,
    output logic          o_strobe,
    output iol_pkg::t_out o_result
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;
    localparam int LW   = iol_pkg::LEN_W;
    localparam int DW   = iol_pkg::DATA_W;

    iol_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_count, n_count;   // elements held
    logic [AW-1:0]        r_rd, n_rd;         // shift loop read pointer
    logic [AW-1:0]        r_last, n_last;     // address read last cycle
    logic                 r_pend, n_pend;     // read data in flight
    logic [AW-1:0]        r_pos, n_pos;       // target slot
    logic signed [DW-1:0] r_word, n_word;     // word to insert / word removed
    logic                 r_strobe, n_strobe;
    iol_pkg::t_out        r_res, n_res;

    // RAM port controls
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    // Command decode helpers
    logic            accept;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            pos_in_list;
    logic            full;
    logic [AW-1:0]   ins_pos;
    logic [AW-1:0]   last_idx;

    assign accept      = start && !busy;
    assign pos_ext     = CMPW'(i_cmd.position);
    assign cnt_ext     = CMPW'(r_count);
    assign pos_in_list = pos_ext < cnt_ext;
    assign full        = r_count >= CW'(CAPACITY);
    assign last_idx    = AW'(r_count - CW'(1));

    // Insert slot: front, back, or the index clamped to the length.
    always_comb begin
        case (i_cmd.cmd)
            iol_pkg::CMD_ADD_FRONT: ins_pos = '0;
            iol_pkg::CMD_ADD_AT:    ins_pos = pos_in_list ? AW'(pos_ext) : AW'(r_count);
            default:                ins_pos = AW'(r_count);
        endcase
    end

    iol_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iol_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.cmd)
                        iol_pkg::CMD_ADD_FRONT, iol_pkg::CMD_ADD_BACK,
                        iol_pkg::CMD_ADD_AT: begin
                            if (!full) begin
                                n_state = (CW'(ins_pos) == r_count) ? iol_pkg::S_PUT
                                                                    : iol_pkg::S_INS;
                            end
                        end
                        iol_pkg::CMD_RM_FRONT, iol_pkg::CMD_RM_BACK: begin
                            if (r_count != '0) begin
                                n_state = iol_pkg::S_RMV;
                            end
                        end
                        iol_pkg::CMD_RM_AT: begin
                            if (pos_in_list) begin
                                n_state = iol_pkg::S_RMV;
                            end
                        end
                        iol_pkg::CMD_GET: begin
                            if (pos_in_list) begin
                                n_state = iol_pkg::S_GET;
                            end
                        end
                        default: n_state = iol_pkg::S_IDLE;
                    endcase
                end
            end
            iol_pkg::S_INS:   if (r_rd == r_pos) n_state = iol_pkg::S_INS_W;
            iol_pkg::S_INS_W: n_state = iol_pkg::S_PUT;
            iol_pkg::S_PUT:   n_state = iol_pkg::S_IDLE;
            iol_pkg::S_RMV:   if (r_rd == last_idx) n_state = iol_pkg::S_RMV_W;
            iol_pkg::S_RMV_W: n_state = iol_pkg::S_IDLE;
            iol_pkg::S_GET:   n_state = iol_pkg::S_GET_W;
            iol_pkg::S_GET_W: n_state = iol_pkg::S_IDLE;
            default:          n_state = iol_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM controls and result
    always_comb begin
        n_count   = r_count;
        n_rd      = r_rd;
        n_last    = r_last;
        n_pend    = r_pend;
        n_pos     = r_pos;
        n_word    = r_word;
        n_strobe  = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = ram_rdata;
        ram_raddr = r_rd;
        busy      = r_state != iol_pkg::S_IDLE;

        unique case (r_state)
            iol_pkg::S_IDLE: begin
                if (accept) begin
                    n_pend = 1'b0;
                    n_word = i_cmd.data_in;
                    // default answer: failure, no change
                    n_res.data_out = '0;
                    n_res.ok       = 1'b0;
                    n_res.length   = LW'(r_count);
                    unique case (i_cmd.cmd)
                        iol_pkg::CMD_ADD_FRONT, iol_pkg::CMD_ADD_BACK,
                        iol_pkg::CMD_ADD_AT: begin
                            n_pos    = ins_pos;
                            n_rd     = last_idx;   // shift from the back down
                            n_strobe = full;
                        end
                        iol_pkg::CMD_RM_FRONT: begin
                            n_pos    = '0;
                            n_rd     = '0;
                            n_strobe = r_count == '0;
                        end
                        iol_pkg::CMD_RM_BACK: begin
                            n_pos    = last_idx;
                            n_rd     = last_idx;
                            n_strobe = r_count == '0;
                        end
                        iol_pkg::CMD_RM_AT, iol_pkg::CMD_GET: begin
                            n_pos    = AW'(pos_ext);
                            n_rd     = AW'(pos_ext);
                            n_strobe = !pos_in_list;
                        end
                        default: begin
                            n_res.ok = 1'b1;
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            iol_pkg::S_INS: begin
                // read slot i, write it back to slot i+1 next cycle
                ram_raddr = r_rd;
                ram_we    = r_pend;
                ram_waddr = r_last + AW'(1);
                n_last    = r_rd;
                n_pend    = 1'b1;
                n_rd      = r_rd - AW'(1);
            end
            iol_pkg::S_INS_W: begin
                ram_we    = 1'b1;
                ram_waddr = r_last + AW'(1);
            end
            iol_pkg::S_PUT: begin
                ram_we         = 1'b1;
                ram_waddr      = r_pos;
                ram_wdata      = r_word;
                n_count        = r_count + CW'(1);
                n_res.data_out = '0;
                n_res.ok       = 1'b1;
                n_res.length   = LW'(n_count);
                n_strobe       = 1'b1;
            end
            iol_pkg::S_RMV: begin
                // first word read is the one removed; later ones move down a slot
                ram_raddr = r_rd;
                ram_we    = r_pend && (r_last != r_pos);
                ram_waddr = r_last - AW'(1);
                if (r_pend && (r_last == r_pos)) begin
                    n_word = ram_rdata;
                end
                n_last = r_rd;
                n_pend = 1'b1;
                n_rd   = r_rd + AW'(1);
            end
            iol_pkg::S_RMV_W: begin
                ram_we         = r_last != r_pos;
                ram_waddr      = r_last - AW'(1);
                n_count        = r_count - CW'(1);
                n_res.data_out = (r_last == r_pos) ? $signed(ram_rdata) : r_word;
                n_res.ok       = 1'b1;
                n_res.length   = LW'(n_count);
                n_strobe       = 1'b1;
            end
            iol_pkg::S_GET: begin
                ram_raddr = r_pos;
            end
            iol_pkg::S_GET_W: begin
                n_res.data_out = $signed(ram_rdata);
                n_res.ok       = 1'b1;
                n_res.length   = LW'(r_count);
                n_strobe       = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iol_pkg::S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rd   <= n_rd;
        r_last <= n_last;
        r_pos  <= n_pos;
        r_word <= n_word;
        r_res  <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

### rtl/core/iol_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module iol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
